/* design/bec_pkg.sv */
// Package for the button event classifier.
// Holds widths, register indexes, event codes and the queued event record.
// No dependencies.
package bec_pkg;

	localparam int NUM_BUTTONS = 10;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CNT_W-1:0] HOLD_MAX = {CNT_W{1'b1}};

	localparam logic [NUM_BUTTONS-1:0] RST_ENABLE      = '0;
	localparam logic [NUM_BUTTONS-1:0] RST_ACTIVE_HIGH = '1;
	localparam logic [CNT_W-1:0]       RST_SHORT_TH    = 16'd2;
	localparam logic [CNT_W-1:0]       RST_LONG_TH     = 16'd100;
	localparam logic [CNT_W-1:0]       RST_REPEAT_TH   = 16'd150;
	localparam logic [CNT_W-1:0]       RST_PERIOD      = 16'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_MASK,
		REG_ACTIVE_HIGH_MASK,
		REG_SHORT_TH,
		REG_LONG_TH,
		REG_REPEAT_TH,
		REG_REPEAT_PERIOD
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_PRESS,
		EV_RELEASE,
		EV_SHORT,
		EV_LONG
	} event_code_t;

	typedef struct packed {
		logic [IDX_W-1:0] button;
		event_code_t      code;
		logic             last;
	} bec_event_t;

endpackage

/* design/bec_channels_if.sv */
// Handshake channels of the button event classifier: sample in, event out,
// configuration write. Depends on bec_pkg.
interface bec_sample_if;
	logic                       valid;
	logic                       ready;
	logic [bec_pkg::IDX_W-1:0]  button_index;
	logic                       raw_level;

	modport source (output valid, output button_index, output raw_level, input ready);
	modport sink   (input valid, input button_index, input raw_level, output ready);
endinterface

interface bec_result_if;
	logic                       valid;
	logic                       ready;
	logic [bec_pkg::IDX_W-1:0]  source_button;
	logic [1:0]                 event_code;
	logic                       last_of_run;

	modport source (output valid, output source_button, output event_code,
		output last_of_run, input ready);
	modport sink   (input valid, input source_button, input event_code,
		input last_of_run, output ready);
endinterface

interface bec_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bec_pkg::CFG_IDX_W-1:0]   index;
	logic [bec_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/button_event_classifier.sv */
// Button event classifier top level: per-button press, release, short, long
// and auto-repeat detection. Depends on bec_pkg and bec_channels_if.
//
// Flow: a sample is registered on transfer; its events are written into the result
// queue once it has room for both, and the first is offered as soon as it is queued.
// Throughput: one sample per cycle while the result queue has room for two events;
// a sample writes both of its events at once, but the single-read queue drains them singly.
// Reset: registers take their default values, button state clears, queue empties.
module button_event_classifier (
	input  logic      clk,
	input  logic      arst_n,
	bec_sample_if.sink   sample,
	bec_result_if.source result,
	bec_cfg_if.sink      cfg
);
	import bec_pkg::*;

	// configuration
	logic [NUM_BUTTONS-1:0] enable_q;
	logic [NUM_BUTTONS-1:0] active_high_q;
	logic [CNT_W-1:0]       short_th_q;
	logic [CNT_W-1:0]       long_th_q;
	logic [CNT_W-1:0]       repeat_th_q;
	logic [CNT_W-1:0]       period_q;

	// input stage
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             level_s1;

	// per-button state
	logic             prev_q  [NUM_BUTTONS];
	logic [CNT_W-1:0] hold_q  [NUM_BUTTONS];
	logic [CNT_W-1:0] phase_q [NUM_BUTTONS];

	// result queue
	bec_event_t        q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic             fire_s1;
	logic             in_range;
	logic             btn_ok;
	logic             pressed;
	logic             prev_cur;
	logic [CNT_W-1:0] hold_cur;
	logic [CNT_W-1:0] phase_cur;
	logic [CNT_W-1:0] hold_inc;
	logic             advanced;
	logic [CNT_W:0]   ph_sum;
	logic [CNT_W-1:0] period_eff;
	logic [CNT_W-1:0] ph_next;
	logic             repeat_ev;
	logic             long_ev;
	logic             short_ev;
	logic             upd;
	logic             new_prev;
	logic [CNT_W-1:0] new_hold;
	logic [CNT_W-1:0] new_phase;
	logic [1:0]       n_ev;
	event_code_t      code0;
	event_code_t      code1;
	bec_event_t       ev0;
	bec_event_t       ev1;
	logic             pop;
	logic [1:0]       push_n;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= RST_ENABLE;
			active_high_q <= RST_ACTIVE_HIGH;
			short_th_q    <= RST_SHORT_TH;
			long_th_q     <= RST_LONG_TH;
			repeat_th_q   <= RST_REPEAT_TH;
			period_q      <= RST_PERIOD;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ENABLE_MASK:      enable_q      <= cfg.data[NUM_BUTTONS-1:0];
				REG_ACTIVE_HIGH_MASK: active_high_q <= cfg.data[NUM_BUTTONS-1:0];
				REG_SHORT_TH:         short_th_q    <= cfg.data;
				REG_LONG_TH:          long_th_q     <= cfg.data;
				REG_REPEAT_TH:        repeat_th_q   <= cfg.data;
				REG_REPEAT_PERIOD:    period_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	// hold a sample until the queue has room for both of its events
	assign fire_s1      = valid_s1 && (count_q <= QCNT_W'(QDEPTH - 2));
	assign sample.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			idx_s1   <= sample.button_index;
			level_s1 <= sample.raw_level;
		end
	end

	always_comb begin
		in_range  = idx_s1 < IDX_W'(NUM_BUTTONS);
		btn_ok    = in_range ? enable_q[idx_s1] : 1'b0;
		pressed   = in_range ? (level_s1 == active_high_q[idx_s1]) : 1'b0;
		prev_cur  = in_range ? prev_q[idx_s1] : 1'b0;
		hold_cur  = in_range ? hold_q[idx_s1] : '0;
		phase_cur = in_range ? phase_q[idx_s1] : '0;

		advanced   = hold_cur != HOLD_MAX;
		hold_inc   = advanced ? hold_cur + CNT_W'(1) : hold_cur;
		period_eff = (period_q == '0) ? CNT_W'(1) : period_q;
		ph_sum     = {1'b0, phase_cur} + (CNT_W+1)'(1);
		ph_next    = (ph_sum >= {1'b0, period_eff}) ? '0 : ph_sum[CNT_W-1:0];
		repeat_ev  = (hold_inc > repeat_th_q) && (ph_next == '0);
		long_ev    = advanced && ({1'b0, hold_inc} == ({1'b0, long_th_q} + (CNT_W+1)'(1)));
		short_ev   = (hold_cur > short_th_q) && (hold_cur < long_th_q);

		new_prev  = pressed;
		new_hold  = '0;
		new_phase = '0;
		n_ev      = 2'd0;
		code0     = EV_PRESS;
		code1     = EV_LONG;
		if (pressed != prev_cur) begin
			if (pressed) begin
				n_ev = 2'd1;
			end else begin
				code0 = EV_RELEASE;
				code1 = EV_SHORT;
				n_ev  = short_ev ? 2'd2 : 2'd1;
			end
		end else if (pressed) begin
			new_hold  = hold_inc;
			new_phase = ph_next;
			if (repeat_ev && long_ev) begin
				n_ev = 2'd2;
			end else if (repeat_ev) begin
				n_ev = 2'd1;
			end else if (long_ev) begin
				code0 = EV_LONG;
				n_ev  = 2'd1;
			end
		end

		upd    = fire_s1 && btn_ok;
		push_n = upd ? n_ev : 2'd0;
		ev0    = '{button: idx_s1, code: code0, last: (n_ev == 2'd1)};
		ev1    = '{button: idx_s1, code: code1, last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				prev_q[i]  <= 1'b0;
				hold_q[i]  <= '0;
				phase_q[i] <= '0;
			end
		end else if (upd) begin
			prev_q[idx_s1]  <= new_prev;
			hold_q[idx_s1]  <= new_hold;
			phase_q[idx_s1] <= new_phase;
		end
	end

	// result queue
	assign pop                  = result.valid && result.ready;
	assign result.valid         = count_q != '0;
	assign result.source_button = q_mem[rd_ptr_q].button;
	assign result.event_code    = q_mem[rd_ptr_q].code;
	assign result.last_of_run   = q_mem[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wr_ptr_q] <= ev0;
		end
		if (push_n == 2'd2) begin
			q_mem[wr_ptr_q + QPTR_W'(1)] <= ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

endmodule
